// ===== hw/rtl/gbs_pkg.sv =====
// Shared types and constants for the greedy box suppression block.
package gbs_pkg;

    localparam int MAX_KEPT_DEFAULT   = 256;
    localparam int COORD_BITS_DEFAULT = 16;

    localparam int THR_BITS      = 16;
    localparam int INDEX_BITS    = 16;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [THR_BITS-1:0] THRESHOLD_RESET = 16'd26214;

    // Register index, taken from the word address bit of paddr.
    localparam logic REG_OVERLAP_THRESHOLD = 1'b0;

    // Compare issued towards the overlap pipeline.
    typedef struct packed {
        logic valid;
        logic last;
    } gbs_issue_t;

    // Outcome of one compare leaving the overlap pipeline.
    typedef struct packed {
        logic valid;
        logic last;
        logic hit;
    } gbs_hit_t;

endpackage

// ===== hw/rtl/gbs_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module gbs_ram #(
    parameter int WIDTH     = 64,
    parameter int DEPTH     = 256,
    parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/gbs_iou_pipe.sv =====
// Pipelined overlap test of the current box against one stored box per cycle.
module gbs_iou_pipe
    import gbs_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  gbs_issue_t                   issue,
    input  logic [4*COORD_BITS-1:0]      rd_data,
    input  logic signed [COORD_BITS-1:0] cur_left,
    input  logic signed [COORD_BITS-1:0] cur_top,
    input  logic [COORD_BITS-1:0]        cur_width,
    input  logic [COORD_BITS-1:0]        cur_height,
    input  logic [THR_BITS-1:0]          threshold,
    output gbs_hit_t                     result
);

    localparam int CB = COORD_BITS;
    localparam int EW = CB + 2;
    localparam int AW = 2 * CB;
    localparam int UW = AW + 1;
    localparam int PW = UW + THR_BITS;

    function automatic logic [CB-1:0] ovl_len(
        input logic signed [EW-1:0] a0,
        input logic signed [EW-1:0] a1,
        input logic signed [EW-1:0] b0,
        input logic signed [EW-1:0] b1
    );
        logic signed [EW-1:0] lo;
        logic signed [EW-1:0] hi;
        logic signed [EW-1:0] diff;
        lo   = (a0 > b0) ? a0 : b0;
        hi   = (a1 < b1) ? a1 : b1;
        diff = hi - lo;
        return (hi > lo) ? diff[CB-1:0] : '0;
    endfunction

    // Valid/last tags, one per stage.
    gbs_issue_t tag_r_reg, tag_s1_reg, tag_s2_reg, tag_s3_reg, tag_s4_reg;
    gbs_hit_t   hit_reg;

    logic signed [CB-1:0] k_left, k_top;
    logic [CB-1:0]        k_width, k_height;
    logic signed [EW-1:0] a_l, a_r, a_t, a_b, b_l, b_r, b_t, b_b;

    logic [CB-1:0] iw_reg, ih_reg, kw_reg, kh_reg;
    logic [AW-1:0] area_reg, inter_s2_reg, karea_reg;
    logic [AW-1:0] inter_s3_reg, inter_s4_reg;
    logic [UW-1:0] uni_reg;
    logic          uni_nz_reg;
    logic [PW-1:0] prod_reg;
    logic [PW-1:0] lhs;

    assign k_left   = rd_data[4*CB-1:3*CB];
    assign k_top    = rd_data[3*CB-1:2*CB];
    assign k_width  = rd_data[2*CB-1:CB];
    assign k_height = rd_data[CB-1:0];

    assign a_l = EW'(cur_left);
    assign a_t = EW'(cur_top);
    assign a_r = a_l + $signed({2'b00, cur_width});
    assign a_b = a_t + $signed({2'b00, cur_height});
    assign b_l = EW'(k_left);
    assign b_t = EW'(k_top);
    assign b_r = b_l + $signed({2'b00, k_width});
    assign b_b = b_t + $signed({2'b00, k_height});

    assign lhs = {1'b0, inter_s4_reg, {THR_BITS{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_r_reg  <= '0;
            tag_s1_reg <= '0;
            tag_s2_reg <= '0;
            tag_s3_reg <= '0;
            tag_s4_reg <= '0;
            hit_reg    <= '0;
        end
        else
        begin
            tag_r_reg     <= issue;
            tag_s1_reg    <= tag_r_reg;
            tag_s2_reg    <= tag_s1_reg;
            tag_s3_reg    <= tag_s2_reg;
            tag_s4_reg    <= tag_s3_reg;
            hit_reg.valid <= tag_s4_reg.valid;
            hit_reg.last  <= tag_s4_reg.last;
            hit_reg.hit   <= tag_s4_reg.valid && uni_nz_reg && (lhs > prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        // The current box is held for the whole item, so its area is settled early.
        area_reg     <= cur_width * cur_height;
        iw_reg       <= ovl_len(a_l, a_r, b_l, b_r);
        ih_reg       <= ovl_len(a_t, a_b, b_t, b_b);
        kw_reg       <= k_width;
        kh_reg       <= k_height;
        inter_s2_reg <= iw_reg * ih_reg;
        karea_reg    <= kw_reg * kh_reg;
        uni_reg      <= UW'(area_reg) + UW'(karea_reg) - UW'(inter_s2_reg);
        inter_s3_reg <= inter_s2_reg;
        prod_reg     <= uni_reg * threshold;
        uni_nz_reg   <= (uni_reg != '0);
        inter_s4_reg <= inter_s3_reg;
    end

    assign result = hit_reg;

endmodule

// ===== hw/rtl/greedy_box_suppression_top.sv =====
// Top level of the greedy box suppression block: control, registers and result port.
// Boxes are handled one at a time: busy stays high until a result is reported, and a new
// box is accepted only while idle. Each stored box takes one read from the store and one
// pass through the overlap pipeline. Reset clears the kept count and frame position, sets
// the threshold to 0.4; the store needs no clearing.
// Results last one cycle on done and the receiver cannot stall them.
module greedy_box_suppression_top
    import gbs_pkg::*;
#(
    parameter int MAX_KEPT   = MAX_KEPT_DEFAULT,
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // Command channel
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] box_left,
    input  logic signed [COORD_BITS-1:0] box_top,
    input  logic [COORD_BITS-1:0]        box_width,
    input  logic [COORD_BITS-1:0]        box_height,
    input  logic                         frame_end,
    // Result channel
    output logic                         done,
    output logic                         kept,
    output logic [INDEX_BITS-1:0]        box_index,
    output logic                         store_overflow,
    output logic                         frame_done,
    // Configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [CFG_ADDR_BITS-1:0]     paddr,
    input  logic [CFG_DATA_BITS-1:0]     pwdata,
    output logic [CFG_DATA_BITS-1:0]     prdata,
    output logic                         pready
);

    // The store address needs at least one bit; the count must be able to hold MAX_KEPT.
    localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CW = $clog2(MAX_KEPT + 1);
    localparam int RW = 4 * COORD_BITS;
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_KEPT);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } gbs_state_t;

    gbs_state_t state_reg, state_next;

    logic [THR_BITS-1:0]   threshold_reg, threshold_next;
    logic [CW-1:0]         kept_count_reg, kept_count_next;
    logic [INDEX_BITS-1:0] position_reg, position_next;
    logic [CW-1:0]         scan_idx_reg, scan_idx_next;
    logic                  suppress_reg, suppress_next;

    // The box under test, held for the whole item.
    logic signed [COORD_BITS-1:0] cur_left_reg, cur_top_reg;
    logic [COORD_BITS-1:0]        cur_width_reg, cur_height_reg;
    logic                         cur_fend_reg;

    logic                  done_reg, done_next;
    logic                  kept_reg, ovf_reg, fdone_reg;
    logic [INDEX_BITS-1:0] index_reg;

    logic       accept;
    logic       cfg_write;
    logic       keep;
    logic       has_room;
    logic       wr_en;
    logic       rd_en;
    logic       scan_last;
    gbs_issue_t issue;
    gbs_hit_t   hit;
    logic [RW-1:0] rd_data;

    assign accept    = start && !busy;
    assign cfg_write = psel && penable && pwrite && pready;
    assign keep      = !suppress_reg;
    assign has_room  = (kept_count_reg < COUNT_MAX);
    assign wr_en     = (state_reg == ST_FINISH) && keep && has_room;
    assign scan_last = (scan_idx_reg == (kept_count_reg - CW'(1)));
    assign rd_en     = (state_reg == ST_SCAN);

    assign issue.valid = rd_en;
    assign issue.last  = rd_en && scan_last;

    // The store holds only the corner and the size; right and bottom edges are rebuilt on read.
    gbs_ram #(
        .WIDTH     (RW),
        .DEPTH     (MAX_KEPT),
        .ADDR_BITS (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (kept_count_reg[AW-1:0]),
        .wr_data ({cur_left_reg, cur_top_reg, cur_width_reg, cur_height_reg}),
        .rd_en   (rd_en),
        .rd_addr (scan_idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    gbs_iou_pipe #(
        .COORD_BITS (COORD_BITS)
    ) u_iou (
        .clk        (clk),
        .rst_n      (rst_n),
        .issue      (issue),
        .rd_data    (rd_data),
        .cur_left   (cur_left_reg),
        .cur_top    (cur_top_reg),
        .cur_width  (cur_width_reg),
        .cur_height (cur_height_reg),
        .threshold  (threshold_reg),
        .result     (hit)
    );

    // Sequencer: scan every stored box, wait for the pipeline to empty, then report.
    always_comb
    begin
        state_next      = state_reg;
        scan_idx_next   = scan_idx_reg;
        suppress_next   = suppress_reg;
        kept_count_next = kept_count_reg;
        position_next   = position_reg;
        done_next       = 1'b0;

        if (hit.valid && hit.hit)
        begin
            suppress_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    scan_idx_next = '0;
                    suppress_next = 1'b0;
                    state_next    = (kept_count_reg == '0) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                scan_idx_next = scan_idx_reg + CW'(1);
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (hit.valid && hit.last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
                if (keep && has_room)
                begin
                    kept_count_next = kept_count_reg + CW'(1);
                end
                position_next = position_reg + INDEX_BITS'(1);
                // The last box of a frame empties the store and restarts the position count.
                if (cur_fend_reg)
                begin
                    kept_count_next = '0;
                    position_next   = '0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The threshold register sits at word 0; only the word address bit is decoded.
    always_comb
    begin
        threshold_next = threshold_reg;
        if (cfg_write && (paddr[2] == REG_OVERLAP_THRESHOLD))
        begin
            threshold_next = pwdata[THR_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            threshold_reg  <= THRESHOLD_RESET;
            kept_count_reg <= '0;
            position_reg   <= '0;
            scan_idx_reg   <= '0;
            suppress_reg   <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            threshold_reg  <= threshold_next;
            kept_count_reg <= kept_count_next;
            position_reg   <= position_next;
            scan_idx_reg   <= scan_idx_next;
            suppress_reg   <= suppress_next;
            done_reg       <= done_next;
        end
    end

    // Payload registers: the box at each transfer, the result fields when it is reported.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_left_reg   <= box_left;
            cur_top_reg    <= box_top;
            cur_width_reg  <= box_width;
            cur_height_reg <= box_height;
            cur_fend_reg   <= frame_end;
        end
        if (state_reg == ST_FINISH)
        begin
            kept_reg  <= keep;
            ovf_reg   <= keep && !has_room;
            index_reg <= position_reg;
            fdone_reg <= cur_fend_reg;
        end
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign kept           = kept_reg;
    assign box_index      = index_reg;
    assign store_overflow = ovf_reg;
    assign frame_done     = fdone_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_OVERLAP_THRESHOLD)
                    ? CFG_DATA_BITS'(threshold_reg) : '0;

`ifndef SYNTHESIS
    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_FINISH))
        else $error("result strobe without a finishing cycle");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        kept_count_reg <= COUNT_MAX)
        else $error("kept count beyond store depth");

    a_overflow_only_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (done && store_overflow) |-> kept)
        else $error("overflow reported for a suppressed box");

    a_hit_while_scanning: assert property (@(posedge clk) disable iff (!rst_n)
        hit.valid |-> ((state_reg == ST_SCAN) || (state_reg == ST_DRAIN)))
        else $error("compare outcome outside the scan");

    a_write_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (kept_count_reg == $past(kept_count_reg) + CW'(1))
                  || $past(cur_fend_reg))
        else $error("store write without count advance");
`endif

endmodule
